FILE: rtl/grid_position_histogram_defines.svh
// assertion macros used by the histogram controller
`ifndef GRID_POSITION_HISTOGRAM_DEFINES_SVH
`define GRID_POSITION_HISTOGRAM_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock out of reset
`define GPH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true out of reset
`define GPH_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define GPH_ASSERT(label, prop, msg)
`define GPH_ASSERT_NEVER(label, expr, msg)
`endif

`endif

FILE: rtl/gph_pkg.sv
package gph_pkg;

  // grid geometry
  localparam int MAX_COLS   = 64;
  localparam int MAX_ROWS   = 64;
  localparam int COUNT_BITS = 16;
  localparam int COL_BITS   = $clog2(MAX_COLS);
  localparam int ROW_BITS   = $clog2(MAX_ROWS);
  localparam int ADDR_BITS  = COL_BITS + ROW_BITS;
  localparam int MEM_DEPTH  = 1 << ADDR_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // field widths
  localparam int POS_BITS  = 16;
  localparam int DIFF_BITS = POS_BITS + 1;
  localparam int MAG_BITS  = POS_BITS;
  localparam int BS_BITS   = 11;
  localparam int NB_BITS   = 7;

  // configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  // divider: quotient bits retired per cycle
  localparam int DIV_STEP_BITS = 4;
  localparam int DIV_STEPS     = MAG_BITS / DIV_STEP_BITS;
  localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);

  // clamped bucket count limits
  localparam logic [NB_BITS-1:0] COLS_LIMIT = NB_BITS'(MAX_COLS);
  localparam logic [NB_BITS-1:0] ROWS_LIMIT = NB_BITS'(MAX_ROWS);

  // register reset values
  localparam logic signed [POS_BITS-1:0] ORIGIN_RST = '0;
  localparam logic [BS_BITS-1:0] BUCKET_SIZE_RST    = BS_BITS'(1);
  localparam logic [NB_BITS-1:0] BUCKETS_RST        = NB_BITS'(64);

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ORIGIN_X    = 3'd0,
    CFG_ORIGIN_Y    = 3'd1,
    CFG_BUCKET_SIZE = 3'd2,
    CFG_BUCKETS_X   = 3'd3,
    CFG_BUCKETS_Y   = 3'd4
  } cfg_idx_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic div_step;
    logic sweep_wr;
    logic ram_rd;
    logic upd;
    logic load_out;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic new_is_add;
    logic new_is_clear;
    logic sweep_last;
  } ctl_stat_t;

endpackage

FILE: rtl/gph_ram.sv
module gph_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/gph_div.sv
module gph_div (
  input  logic                          clk,
  input  logic                          start,
  input  logic                          step,
  input  logic [gph_pkg::MAG_BITS-1:0]  dividend,
  input  logic [gph_pkg::BS_BITS-1:0]   divisor,
  output logic [gph_pkg::MAG_BITS-1:0]  quotient
);

  logic [gph_pkg::BS_BITS-1:0]  rem_r, rem_nxt;
  logic [gph_pkg::MAG_BITS-1:0] quo_r, quo_nxt;

  // restoring division, several quotient bits per cycle while step is high
  always_comb begin
    logic [gph_pkg::BS_BITS-1:0]  rem;
    logic [gph_pkg::MAG_BITS-1:0] quo;
    logic [gph_pkg::BS_BITS:0]    trial;
    rem   = rem_r;
    quo   = quo_r;
    trial = '0;
    for (int i = 0; i < gph_pkg::DIV_STEP_BITS; i++) begin
      trial = {rem, quo[gph_pkg::MAG_BITS-1]};
      quo   = {quo[gph_pkg::MAG_BITS-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        trial  = trial - {1'b0, divisor};
        quo[0] = 1'b1;
      end
      rem = trial[gph_pkg::BS_BITS-1:0];
    end
    rem_nxt = rem;
    quo_nxt = quo;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient = quo_r;

endmodule

FILE: rtl/gph_datapath.sv
module gph_datapath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [gph_pkg::CFG_IDX_BITS-1:0]       cfg_idx,
  input  logic [gph_pkg::CFG_DATA_BITS-1:0]      cfg_wdata,
  input  logic [1:0]                             in_cmd,
  input  logic signed [gph_pkg::POS_BITS-1:0]    in_pos_x,
  input  logic signed [gph_pkg::POS_BITS-1:0]    in_pos_y,
  input  logic [gph_pkg::COL_BITS-1:0]           in_read_col,
  input  logic [gph_pkg::ROW_BITS-1:0]           in_read_row,
  input  gph_pkg::ctl_cmd_t                      ctl,
  output gph_pkg::ctl_stat_t                     stat,
  output logic [gph_pkg::COUNT_BITS-1:0]         out_count,
  output logic [gph_pkg::COL_BITS-1:0]           out_bucket_col,
  output logic [gph_pkg::ROW_BITS-1:0]           out_bucket_row,
  output logic                                   out_in_range,
  output logic                                   out_saturated
);

  // configuration registers
  logic signed [gph_pkg::POS_BITS-1:0] origin_x_r, origin_y_r;
  logic [gph_pkg::BS_BITS-1:0]         bucket_size_r;
  logic [gph_pkg::NB_BITS-1:0]         buckets_x_r, buckets_y_r;

  // item registers
  logic [1:0]                      cmd_r;
  logic [gph_pkg::COL_BITS-1:0]    rc_r;
  logic [gph_pkg::ROW_BITS-1:0]    rr_r;
  logic                            neg_x_r, neg_y_r;

  // clearing sweep
  logic [gph_pkg::ADDR_BITS-1:0]   sweep_r, sweep_nxt;

  // result and output registers
  logic [gph_pkg::COUNT_BITS-1:0]  res_cnt_r, res_cnt_nxt;
  logic [gph_pkg::COL_BITS-1:0]    res_col_r, res_col_nxt;
  logic [gph_pkg::ROW_BITS-1:0]    res_row_r, res_row_nxt;
  logic                            res_inr_r, res_inr_nxt;
  logic                            res_sat_r, res_sat_nxt;
  logic [gph_pkg::COUNT_BITS-1:0]  out_cnt_r;
  logic [gph_pkg::COL_BITS-1:0]    out_col_r;
  logic [gph_pkg::ROW_BITS-1:0]    out_row_r;
  logic                            out_inr_r, out_sat_r;

  logic signed [gph_pkg::DIFF_BITS-1:0] diff_x, diff_y, negd_x, negd_y;
  logic [gph_pkg::MAG_BITS-1:0]   mag_x, mag_y, q_x, q_y;
  logic [gph_pkg::BS_BITS-1:0]    bs_eff;
  logic [gph_pkg::NB_BITS-1:0]    cols_eff, rows_eff;
  logic                           x_ok, y_ok, add_ok, rd_ok;
  logic [gph_pkg::ADDR_BITS-1:0]  addr_c, waddr;
  logic                           ram_we;
  logic [gph_pkg::COUNT_BITS-1:0] ram_wdata, rdata, new_cnt;

  // register writes, out-of-list indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r    <= gph_pkg::ORIGIN_RST;
      origin_y_r    <= gph_pkg::ORIGIN_RST;
      bucket_size_r <= gph_pkg::BUCKET_SIZE_RST;
      buckets_x_r   <= gph_pkg::BUCKETS_RST;
      buckets_y_r   <= gph_pkg::BUCKETS_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        gph_pkg::CFG_ORIGIN_X:    origin_x_r    <= cfg_wdata;
        gph_pkg::CFG_ORIGIN_Y:    origin_y_r    <= cfg_wdata;
        gph_pkg::CFG_BUCKET_SIZE: bucket_size_r <= cfg_wdata[gph_pkg::BS_BITS-1:0];
        gph_pkg::CFG_BUCKETS_X:   buckets_x_r   <= cfg_wdata[gph_pkg::NB_BITS-1:0];
        gph_pkg::CFG_BUCKETS_Y:   buckets_y_r   <= cfg_wdata[gph_pkg::NB_BITS-1:0];
        default: ;
      endcase
    end
  end

  // effective bucket size and grid extent
  assign bs_eff   = (bucket_size_r == '0) ? gph_pkg::BS_BITS'(1) : bucket_size_r;
  assign cols_eff = (buckets_x_r > gph_pkg::COLS_LIMIT) ? gph_pkg::COLS_LIMIT : buckets_x_r;
  assign rows_eff = (buckets_y_r > gph_pkg::ROWS_LIMIT) ? gph_pkg::ROWS_LIMIT : buckets_y_r;

  // offset from origin as sign and magnitude
  assign diff_x = gph_pkg::DIFF_BITS'(in_pos_x) - gph_pkg::DIFF_BITS'(origin_x_r);
  assign diff_y = gph_pkg::DIFF_BITS'(in_pos_y) - gph_pkg::DIFF_BITS'(origin_y_r);
  assign negd_x = -diff_x;
  assign negd_y = -diff_y;
  assign mag_x  = diff_x[gph_pkg::DIFF_BITS-1] ? negd_x[gph_pkg::MAG_BITS-1:0]
                                               : diff_x[gph_pkg::MAG_BITS-1:0];
  assign mag_y  = diff_y[gph_pkg::DIFF_BITS-1] ? negd_y[gph_pkg::MAG_BITS-1:0]
                                               : diff_y[gph_pkg::MAG_BITS-1:0];

  // capture the accepted transaction
  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      cmd_r   <= in_cmd;
      rc_r    <= in_read_col;
      rr_r    <= in_read_row;
      neg_x_r <= diff_x[gph_pkg::DIFF_BITS-1];
      neg_y_r <= diff_y[gph_pkg::DIFF_BITS-1];
    end
  end

  gph_div u_div_x (
    .clk      (clk),
    .start    (ctl.load_item),
    .step     (ctl.div_step),
    .dividend (mag_x),
    .divisor  (bs_eff),
    .quotient (q_x)
  );

  gph_div u_div_y (
    .clk      (clk),
    .start    (ctl.load_item),
    .step     (ctl.div_step),
    .dividend (mag_y),
    .divisor  (bs_eff),
    .quotient (q_y)
  );

  // a negative offset only lands in bucket zero when it truncates to zero
  assign x_ok   = (!neg_x_r || (q_x == '0)) && (q_x < gph_pkg::MAG_BITS'(cols_eff));
  assign y_ok   = (!neg_y_r || (q_y == '0)) && (q_y < gph_pkg::MAG_BITS'(rows_eff));
  assign add_ok = x_ok && y_ok;
  assign rd_ok  = (gph_pkg::NB_BITS'(rc_r) < cols_eff) && (gph_pkg::NB_BITS'(rr_r) < rows_eff);

  // bucket address, row major
  assign addr_c = (cmd_r == gph_pkg::CMD_ADD) ?
                  {q_y[gph_pkg::ROW_BITS-1:0], q_x[gph_pkg::COL_BITS-1:0]} : {rr_r, rc_r};

  // saturating increment
  assign new_cnt = (rdata == gph_pkg::COUNT_MAX) ? rdata
                                                 : rdata + gph_pkg::COUNT_BITS'(1);

  // clearing sweep address
  assign sweep_nxt = sweep_r + gph_pkg::ADDR_BITS'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (ctl.sweep_wr) begin
      sweep_r <= sweep_nxt;
    end
  end

  // ram write select
  assign ram_we    = ctl.sweep_wr || (ctl.upd && (cmd_r == gph_pkg::CMD_ADD) && add_ok);
  assign waddr     = ctl.sweep_wr ? sweep_r : addr_c;
  assign ram_wdata = ctl.sweep_wr ? '0 : new_cnt;

  gph_ram #(
    .WIDTH (gph_pkg::COUNT_BITS),
    .DEPTH (gph_pkg::MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (ram_wdata),
    .re    (ctl.ram_rd),
    .raddr (addr_c),
    .rdata (rdata)
  );

  // result fields per command
  always_comb begin
    res_cnt_nxt = '0;
    res_col_nxt = '0;
    res_row_nxt = '0;
    res_inr_nxt = 1'b0;
    res_sat_nxt = 1'b0;
    case (cmd_r)
      gph_pkg::CMD_ADD: begin
        if (add_ok) begin
          res_cnt_nxt = new_cnt;
          res_col_nxt = q_x[gph_pkg::COL_BITS-1:0];
          res_row_nxt = q_y[gph_pkg::ROW_BITS-1:0];
          res_inr_nxt = 1'b1;
          res_sat_nxt = (new_cnt == gph_pkg::COUNT_MAX);
        end
      end
      gph_pkg::CMD_READ: begin
        res_col_nxt = rc_r;
        res_row_nxt = rr_r;
        if (rd_ok) begin
          res_cnt_nxt = rdata;
          res_inr_nxt = 1'b1;
          res_sat_nxt = (rdata == gph_pkg::COUNT_MAX);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      res_cnt_r <= res_cnt_nxt;
      res_col_r <= res_col_nxt;
      res_row_r <= res_row_nxt;
      res_inr_r <= res_inr_nxt;
      res_sat_r <= res_sat_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_cnt_r <= res_cnt_r;
      out_col_r <= res_col_r;
      out_row_r <= res_row_r;
      out_inr_r <= res_inr_r;
      out_sat_r <= res_sat_r;
    end
  end

  assign out_count      = out_cnt_r;
  assign out_bucket_col = out_col_r;
  assign out_bucket_row = out_row_r;
  assign out_in_range   = out_inr_r;
  assign out_saturated  = out_sat_r;

  // status to controller
  assign stat.new_is_add   = (in_cmd == gph_pkg::CMD_ADD);
  assign stat.new_is_clear = (in_cmd == gph_pkg::CMD_CLEAR);
  assign stat.sweep_last   = &sweep_r;

endmodule

FILE: rtl/gph_ctrl.sv
`include "grid_position_histogram_defines.svh"

module gph_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  gph_pkg::ctl_stat_t stat,
  output gph_pkg::ctl_cmd_t  ctl
);

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_CLEAR = 7'b0001000,
    S_RD    = 7'b0010000,
    S_UPD   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t                            state_r, state_nxt;
  logic [gph_pkg::DIV_CNT_BITS-1:0]  div_cnt_r, div_cnt_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic                              div_last;

  assign div_last = (div_cnt_r == gph_pkg::DIV_CNT_BITS'(gph_pkg::DIV_STEPS - 1));

  // next state and datapath commands
  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    ctl         = '0;
    in_ready    = 1'b0;
    case (state_r)
      S_INIT: begin
        ctl.sweep_wr = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load_item = 1'b1;
          div_cnt_nxt   = '0;
          if (stat.new_is_add) begin
            state_nxt = S_DIV;
          end else if (stat.new_is_clear) begin
            state_nxt = S_CLEAR;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + gph_pkg::DIV_CNT_BITS'(1);
        if (div_last) begin
          state_nxt = S_RD;
        end
      end
      S_CLEAR: begin
        ctl.sweep_wr = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_UPD;
        end
      end
      S_RD: begin
        ctl.ram_rd = 1'b1;
        state_nxt  = S_UPD;
      end
      S_UPD: begin
        ctl.upd   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          ctl.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `GPH_ASSERT_NEVER(a_no_accept_in_sweep, in_ready && (state_r == S_INIT || state_r == S_CLEAR), "transaction accepted during clearing sweep")
  `GPH_ASSERT(a_upd_after_read, (state_r == S_UPD) |-> $past(state_r == S_RD || state_r == S_CLEAR), "update without ram read or sweep")
  `GPH_ASSERT(a_result_posted, (state_r == S_DONE && (!out_valid_r || out_ready)) |=> (out_valid_r && state_r == S_IDLE), "result not posted to output register")
  `GPH_ASSERT(a_div_len, (state_r == S_RD && $past(state_r == S_DIV)) |-> $past(div_last), "divide left early")

endmodule

FILE: rtl/grid_position_histogram.sv
// channel  direction  handshake                payload
// in_      input      in_valid / in_ready      cmd, pos_x, pos_y, read_col, read_row
// out_     output     out_valid / out_ready    count, bucket_col, bucket_row, in_range, saturated
// cfg_     input      cfg_we, no wait          cfg_idx, cfg_wdata
//
// an add runs the divider, 16 quotient bits at 4 bits per cycle, then a ram read and an
// update before the result is posted; read and unused commands skip the divider; clear
// runs a zeroing sweep of all 4096 ram words before its update.
// after reset the same sweep runs before the first transaction is accepted.
// a finished result waits in the output register while the next transaction is taken;
// the block stalls only when a new result is ready and the previous one is still unread.
module grid_position_histogram (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [gph_pkg::CFG_IDX_BITS-1:0]     cfg_idx,
  input  logic [gph_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_cmd,
  input  logic signed [gph_pkg::POS_BITS-1:0]  in_pos_x,
  input  logic signed [gph_pkg::POS_BITS-1:0]  in_pos_y,
  input  logic [gph_pkg::COL_BITS-1:0]         in_read_col,
  input  logic [gph_pkg::ROW_BITS-1:0]         in_read_row,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [gph_pkg::COUNT_BITS-1:0]       out_count,
  output logic [gph_pkg::COL_BITS-1:0]         out_bucket_col,
  output logic [gph_pkg::ROW_BITS-1:0]         out_bucket_row,
  output logic                                 out_in_range,
  output logic                                 out_saturated
);

  gph_pkg::ctl_cmd_t  ctl;
  gph_pkg::ctl_stat_t stat;

  gph_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  gph_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .in_cmd         (in_cmd),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_read_col    (in_read_col),
    .in_read_row    (in_read_row),
    .ctl            (ctl),
    .stat           (stat),
    .out_count      (out_count),
    .out_bucket_col (out_bucket_col),
    .out_bucket_row (out_bucket_row),
    .out_in_range   (out_in_range),
    .out_saturated  (out_saturated)
  );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import gph_pkg::*;

  // the fourth command code has no meaning to the block
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [POS_BITS-1:0] pos_x;
    logic [POS_BITS-1:0] pos_y;
    logic [COL_BITS-1:0] read_col;
    logic [ROW_BITS-1:0] read_row;
  } hist_cmd_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic [COL_BITS-1:0]   col;
    logic [ROW_BITS-1:0]   row;
    logic                  in_range;
    logic                  saturated;
  } bin_report_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               in_cmd;
  logic signed [POS_BITS-1:0] in_pos_x;
  logic signed [POS_BITS-1:0] in_pos_y;
  logic [COL_BITS-1:0]      in_read_col;
  logic [ROW_BITS-1:0]      in_read_row;
  logic                     out_valid;
  logic                     out_ready;
  logic [COUNT_BITS-1:0]    out_count;
  logic [COL_BITS-1:0]      out_bucket_col;
  logic [ROW_BITS-1:0]      out_bucket_row;
  logic                     out_in_range;
  logic                     out_saturated;

  // commands waiting to be sent and bin reports still to come back
  hist_cmd_t   cmd_backlog[$];
  bin_report_t bin_reports_due[$];

  int send_idle_pct = 14;
  int recv_idle_pct = 72;
  int hold_request = 0;
  int mismatch_count = 0;
  bit cmd_taken = 1'b0;

  // predictor copy of the configuration and of the bucket store
  logic signed [POS_BITS-1:0] cur_origin_x = ORIGIN_RST;
  logic signed [POS_BITS-1:0] cur_origin_y = ORIGIN_RST;
  logic [BS_BITS-1:0]         cur_bucket_size = BUCKET_SIZE_RST;
  logic [NB_BITS-1:0]         cur_buckets_x = BUCKETS_RST;
  logic [NB_BITS-1:0]         cur_buckets_y = BUCKETS_RST;
  logic [COUNT_BITS-1:0]      grid_counts [MEM_DEPTH] = '{default: '0};

  grid_position_histogram uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_read_col    (in_read_col),
    .in_read_row    (in_read_row),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_count      (out_count),
    .out_bucket_col (out_bucket_col),
    .out_bucket_row (out_bucket_row),
    .out_in_range   (out_in_range),
    .out_saturated  (out_saturated)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin : watchdog
    #10_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic int cols_in_use();
    return (cur_buckets_x > COLS_LIMIT) ? int'(COLS_LIMIT) : int'(cur_buckets_x);
  endfunction

  function automatic int rows_in_use();
    return (cur_buckets_y > ROWS_LIMIT) ? int'(ROWS_LIMIT) : int'(cur_buckets_y);
  endfunction

  function automatic int bucket_span();
    return (cur_bucket_size == '0) ? 1 : int'(cur_bucket_size);
  endfunction

  // bucket index along one axis, -1 when outside the grid
  function automatic int axis_bucket(logic signed [POS_BITS-1:0] pos,
                                     logic signed [POS_BITS-1:0] org, int limit);
    int q;
    q = (int'(pos) - int'(org)) / bucket_span();
    return (q < 0 || q >= limit) ? -1 : q;
  endfunction

  // applies one command to the predicted store and returns its bin report
  function automatic bin_report_t histogram_predict(hist_cmd_t c);
    bin_report_t r;
    int cx, cy, addr;
    r = '0;
    case (c.cmd)
      CMD_ADD: begin
        cx = axis_bucket(c.pos_x, cur_origin_x, cols_in_use());
        cy = axis_bucket(c.pos_y, cur_origin_y, rows_in_use());
        if (cx >= 0 && cy >= 0) begin
          addr = cy * MAX_COLS + cx;
          if (grid_counts[addr] != COUNT_MAX)
            grid_counts[addr] = grid_counts[addr] + 1'b1;
          r.count = grid_counts[addr];
          r.col = COL_BITS'(cx);
          r.row = ROW_BITS'(cy);
          r.in_range = 1'b1;
          r.saturated = (grid_counts[addr] == COUNT_MAX);
        end
      end
      CMD_READ: begin
        r.col = c.read_col;
        r.row = c.read_row;
        if (int'(c.read_col) < cols_in_use() && int'(c.read_row) < rows_in_use()) begin
          addr = int'(c.read_row) * MAX_COLS + int'(c.read_col);
          r.count = grid_counts[addr];
          r.in_range = 1'b1;
          r.saturated = (grid_counts[addr] == COUNT_MAX);
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < MEM_DEPTH; i++)
          grid_counts[i] = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic flag_error(string msg);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s", $time, msg);
  endtask

  task automatic queue_cmd(logic [1:0] op, int x, int y, int c, int r);
    hist_cmd_t item;
    item.cmd = op;
    item.pos_x = POS_BITS'(x);
    item.pos_y = POS_BITS'(y);
    item.read_col = COL_BITS'(c);
    item.read_row = ROW_BITS'(r);
    cmd_backlog.push_back(item);
  endtask

  // register write, only issued while the block is idle
  task automatic write_reg(cfg_idx_t idx, int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= CFG_DATA_BITS'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ORIGIN_X:    cur_origin_x = POS_BITS'(value);
      CFG_ORIGIN_Y:    cur_origin_y = POS_BITS'(value);
      CFG_BUCKET_SIZE: cur_bucket_size = BS_BITS'(value);
      CFG_BUCKETS_X:   cur_buckets_x = NB_BITS'(value);
      CFG_BUCKETS_Y:   cur_buckets_y = NB_BITS'(value);
      default: ;
    endcase
  endtask

  // wait until every command is sent and every report is back
  task automatic settle();
    while (cmd_backlog.size() != 0 || in_valid || bin_reports_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_size();
    int p;
    p = $urandom_range(99);
    if (p < 8) return 0;
    if (p < 16) return 2047;
    if (p < 24) return 1024;
    if (p < 40) return 1;
    return $urandom_range(2, 64);
  endfunction

  function automatic int pick_extent();
    int p;
    p = $urandom_range(99);
    if (p < 6) return 0;
    if (p < 14) return $urandom_range(65, 127);
    if (p < 24) return 64;
    if (p < 55) return $urandom_range(1, 4);
    return $urandom_range(1, 64);
  endfunction

  function automatic int pick_origin();
    if ($urandom_range(3) == 0)
      return $urandom_range(0, 65535);
    return int'($urandom_range(0, 4000)) - 2000;
  endfunction

  // random grid geometry, every register written
  task automatic pick_geometry();
    write_reg(CFG_ORIGIN_X, pick_origin());
    write_reg(CFG_ORIGIN_Y, pick_origin());
    write_reg(CFG_BUCKET_SIZE, pick_size());
    write_reg(CFG_BUCKETS_X, pick_extent());
    write_reg(CFG_BUCKETS_Y, pick_extent());
  endtask

  // offset that mostly lands in the grid, with a margin on both sides
  function automatic int near_offset(int n);
    return int'($urandom_range(0, bucket_span() * (n + 2) - 1)) - bucket_span();
  endfunction

  task automatic queue_random_mix(int n);
    int p, ncol, nrow;
    ncol = cols_in_use();
    nrow = rows_in_use();
    repeat (n) begin
      p = $urandom_range(99);
      if (p < 60)
        queue_cmd(CMD_ADD, int'(cur_origin_x) + near_offset(ncol),
                  int'(cur_origin_y) + near_offset(nrow),
                  $urandom_range(63), $urandom_range(63));
      else if (p < 70)
        queue_cmd(CMD_ADD, $urandom, $urandom, $urandom_range(63), $urandom_range(63));
      else if (p < 85)
        queue_cmd(CMD_READ, $urandom, $urandom,
                  $urandom_range((ncol > 0) ? ncol - 1 : 0),
                  $urandom_range((nrow > 0) ? nrow - 1 : 0));
      else if (p < 95)
        queue_cmd(CMD_READ, $urandom, $urandom, $urandom_range(63), $urandom_range(63));
      else if (p < 99)
        queue_cmd(CMD_UNUSED, $urandom, $urandom, $urandom_range(63), $urandom_range(63));
      else
        queue_cmd(CMD_CLEAR, $urandom, $urandom, $urandom_range(63), $urandom_range(63));
    end
  endtask

  // input driver
  always @(negedge clk) begin : drive_cmds
    hist_cmd_t nxt;
    if (!in_valid || cmd_taken) begin
      cmd_taken = 1'b0;
      if (rst_n && cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = cmd_backlog.pop_front();
        in_cmd <= nxt.cmd;
        in_pos_x <= nxt.pos_x;
        in_pos_y <= nxt.pos_y;
        in_read_col <= nxt.read_col;
        in_read_row <= nxt.read_row;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // input transaction capture and prediction
  always @(posedge clk) begin : capture_cmds
    if (rst_n && in_valid && in_ready) begin
      bin_reports_due.push_back(
        histogram_predict({in_cmd, in_pos_x, in_pos_y, in_read_col, in_read_row}));
      cmd_taken = 1'b1;
    end
  end

  // result ready, with random stalls and one long hold-off
  always @(negedge clk) begin : drive_ready
    int stall_left;
    if (hold_request != 0) begin
      stall_left = hold_request;
      hold_request = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin : check_reports
    bin_report_t seen, want;
    if (rst_n && out_valid && out_ready) begin
      seen = {out_count, out_bucket_col, out_bucket_row, out_in_range, out_saturated};
      if (bin_reports_due.size() == 0) begin
        flag_error($sformatf("unexpected report: count %0d col %0d row %0d rng %0b sat %0b",
                             seen.count, seen.col, seen.row, seen.in_range, seen.saturated));
      end else begin
        want = bin_reports_due.pop_front();
        if (seen.count !== want.count || seen.col !== want.col || seen.row !== want.row ||
            seen.in_range !== want.in_range || seen.saturated !== want.saturated)
          flag_error($sformatf({"report mismatch: exp count %0d col %0d row %0d rng %0b ",
                                "sat %0b, got count %0d col %0d row %0d rng %0b sat %0b"},
                               want.count, want.col, want.row, want.in_range,
                               want.saturated, seen.count, seen.col, seen.row,
                               seen.in_range, seen.saturated));
      end
    end
  end

  // stimulus sequence
  initial begin : stimulus
    int regime, batch;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_cmd = '0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_read_col = '0;
    in_read_row = '0;
    out_ready = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // corners of the reset grid, all commands
    queue_cmd(CMD_ADD, 0, 0, 0, 0);
    queue_cmd(CMD_ADD, 0, 0, 63, 63);
    queue_cmd(CMD_ADD, 63, 63, 0, 0);
    queue_cmd(CMD_ADD, 64, 5, 0, 0);
    queue_cmd(CMD_ADD, 5, 64, 0, 0);
    queue_cmd(CMD_ADD, -1, 3, 0, 0);
    queue_cmd(CMD_ADD, 32767, -32768, 0, 0);
    queue_cmd(CMD_ADD, -32768, 32767, 0, 0);
    queue_cmd(CMD_READ, 0, 0, 0, 0);
    queue_cmd(CMD_READ, -1, -1, 63, 63);
    queue_cmd(CMD_READ, 0, 0, 63, 0);
    queue_cmd(CMD_UNUSED, -1, -1, 63, 63);
    queue_cmd(CMD_CLEAR, -1, -1, 63, 63);
    queue_cmd(CMD_READ, 0, 0, 0, 0);
    settle();

    // extreme origins, wide buckets, small negative offset
    write_reg(CFG_ORIGIN_X, -32768);
    write_reg(CFG_ORIGIN_Y, 32767);
    write_reg(CFG_BUCKET_SIZE, 1024);
    queue_cmd(CMD_ADD, 32767, 32767, 0, 0);
    queue_cmd(CMD_ADD, -32758, 32762, 0, 0);
    queue_cmd(CMD_ADD, -32768, -32768, 0, 0);
    queue_cmd(CMD_READ, 0, 0, 63, 0);
    settle();

    // zero bucket size and an empty grid
    write_reg(CFG_BUCKET_SIZE, 0);
    write_reg(CFG_BUCKETS_X, 0);
    write_reg(CFG_BUCKETS_Y, 127);
    queue_cmd(CMD_ADD, -32765, 32767, 0, 0);
    queue_cmd(CMD_READ, 0, 0, 0, 0);
    queue_cmd(CMD_READ, 0, 0, 63, 63);
    settle();

    // widest bucket, clamped column count, single row
    write_reg(CFG_BUCKET_SIZE, 2047);
    write_reg(CFG_BUCKETS_X, 127);
    write_reg(CFG_BUCKETS_Y, 1);
    queue_cmd(CMD_ADD, 32767, 32767, 0, 0);
    queue_cmd(CMD_READ, 0, 0, 32, 0);
    settle();

    // random traffic under three idle regimes
    for (regime = 0; regime < 3; regime++) begin
      send_idle_pct = (regime == 0) ? 14 : (regime == 1) ? 72 : 0;
      recv_idle_pct = (regime == 0) ? 72 : (regime == 1) ? 14 : 0;
      for (batch = 0; batch < 3; batch++) begin
        pick_geometry();
        queue_random_mix(200);
        if (regime == 2 && batch == 0)
          hold_request = 400;
        settle();
      end
    end

    // pile a run of adds onto one bucket, then read it back
    write_reg(CFG_ORIGIN_X, 0);
    write_reg(CFG_ORIGIN_Y, 0);
    write_reg(CFG_BUCKET_SIZE, 1024);
    write_reg(CFG_BUCKETS_X, 64);
    write_reg(CFG_BUCKETS_Y, 64);
    repeat (20)
      queue_cmd(CMD_ADD, $urandom_range(1024, 2047), $urandom_range(2048, 3071),
                $urandom_range(63), $urandom_range(63));
    queue_cmd(CMD_READ, 0, 0, 1, 2);
    queue_cmd(CMD_ADD, 0, 0, 0, 0);
    settle();

    if (mismatch_count == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

FILE: grid_position_histogram.f
+incdir+rtl
rtl/gph_pkg.sv
rtl/gph_ram.sv
rtl/gph_div.sv
rtl/gph_datapath.sv
rtl/gph_ctrl.sv
rtl/grid_position_histogram.sv
verif/tb_top.sv
